### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication, ignored while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

### rtl/core/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Fixed-point format and port widths shared by the converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// Fraction bits of S, V and the hue fraction; ONE means 1.0
	localparam int FRAC_BITS = 16;
	localparam int FRAC_W    = FRAC_BITS + 1;
	localparam logic [FRAC_W-1:0] ONE = FRAC_W'(1) << FRAC_BITS;

	// Hue in whole degrees and 8-bit colour channels
	localparam int HUE_W  = 16;
	localparam int CHAN_W = 8;

	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic [CHAN_W-1:0] chan_t;

endpackage

### rtl/core/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Hexcone colour conversion in fixed point, six register stages.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------
//  input   | in_valid / in_ready     | hue_degrees, saturation, brightness
//  output  | out_valid / out_ready   | red, green, blue
//
//  One word enters per cycle while in_ready is high; each word passes through
//  stages one to six in order. The stage-six register is the output register.
//  arst_n clears every stage valid bit; payload registers are not reset.
//  A stage loads when it is empty or the stage after it moves, so a stall at
//  out_ready backs up stage by stage and in_ready falls only once all six
//  stages hold a word.
//
module hsv_to_rgb_converter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]     hue_degrees,
	input  logic [hsv2rgb_pkg::FRAC_W-1:0]    saturation,
	input  logic [hsv2rgb_pkg::FRAC_W-1:0]    brightness,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]    red,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]    green,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]    blue
);
	import hsv2rgb_pkg::*;

	`include "assert_macros.svh"

	// Hue / 60 by reciprocal: exact for every 16-bit hue
	localparam int DIV60_SHIFT = HUE_W + 6;
	localparam int DIV60_M_W   = HUE_W + 1;
	localparam logic [DIV60_M_W-1:0] DIV60_M =
		DIV60_M_W'(((64'd1 << DIV60_SHIFT) + 64'd59) / 64'd60);
	localparam int Q60_W = 11;   // hue / 60 stays below 1093

	// (hue / 60) / 6 by reciprocal: exact for every 11-bit quotient
	localparam int DIV6_SHIFT = Q60_W + 3;
	localparam int DIV6_M_W   = Q60_W + 1;
	localparam logic [DIV6_M_W-1:0] DIV6_M =
		DIV6_M_W'(((64'd1 << DIV6_SHIFT) + 64'd5) / 64'd6);
	localparam int Q6_W = 8;     // at most 182

	// f = (rem << FRAC_BITS) / 60 by reciprocal, rem below 60
	localparam int REM_W    = 6;
	localparam int FR_SHIFT = FRAC_BITS + 2 * REM_W;
	localparam int FR_M_W   = FRAC_BITS + REM_W + 1;
	localparam logic [FR_M_W-1:0] FR_M =
		FR_M_W'(((64'd1 << FR_SHIFT) + 64'd59) / 64'd60);

	// Sector codes
	localparam int SEC_W = 3;
	localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
	localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
	localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
	localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
	localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;
	localparam logic [SEC_W-1:0] SEC_MAG_RED = 3'd5;

	// floor(x * 255 / ONE), x at most ONE so the result fits eight bits
	function automatic chan_t to_byte(input frac_t x);
		logic [FRAC_W+CHAN_W-1:0] prod;
		prod = {x, CHAN_W'(0)} - {CHAN_W'(0), x};
		return prod[FRAC_BITS +: CHAN_W];
	endfunction

	// Stage valid bits and advance terms
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;

	assign adv_s6 = !vld_s6 || out_ready;
	assign adv_s5 = !vld_s5 || adv_s6;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;

	assign in_ready  = adv_s1;
	assign out_valid = vld_s6;

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
		end
	end

	// Stage 1: clamp S and V to one, divide hue by 60
	logic [HUE_W+DIV60_M_W-1:0] hue_prod;
	frac_t                      sat_lim, val_lim;
	logic [HUE_W-1:0]           hue_s1;
	logic [Q60_W-1:0]           q60_s1;
	frac_t                      sat_s1, val_s1;

	assign hue_prod = (HUE_W+DIV60_M_W)'(hue_degrees) * (HUE_W+DIV60_M_W)'(DIV60_M);
	assign sat_lim  = (saturation > ONE) ? ONE : saturation;
	assign val_lim  = (brightness > ONE) ? ONE : brightness;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hue_s1 <= hue_degrees;
			q60_s1 <= hue_prod[DIV60_SHIFT +: Q60_W];
			sat_s1 <= sat_lim;
			val_s1 <= val_lim;
		end
	end

	// Stage 2: remainder inside the 60-degree span, divide quotient by 6
	logic [HUE_W-1:0]          q60_x60;
	logic [HUE_W-1:0]          rem_full;
	logic [Q60_W+DIV6_M_W-1:0] q6_prod;
	logic [REM_W-1:0]          rem_s2;
	logic [Q60_W-1:0]          q60_s2;
	logic [Q6_W-1:0]           q6_s2;
	frac_t                     sat_s2, val_s2;

	assign q60_x60  = (HUE_W'(q60_s1) << 6) - (HUE_W'(q60_s1) << 2);
	assign rem_full = hue_s1 - q60_x60;
	assign q6_prod  = (Q60_W+DIV6_M_W)'(q60_s1) * (Q60_W+DIV6_M_W)'(DIV6_M);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			rem_s2 <= rem_full[REM_W-1:0];
			q60_s2 <= q60_s1;
			q6_s2  <= q6_prod[DIV6_SHIFT +: Q6_W];
			sat_s2 <= sat_s1;
			val_s2 <= val_s1;
		end
	end

	// Stage 3: sector from hue mod 360, fraction f inside the sector
	logic [Q60_W-1:0]        q6_x6;
	logic [Q60_W-1:0]        sec_full;
	logic [REM_W+FR_M_W-1:0] f_prod;
	logic [SEC_W-1:0]        sector_s3;
	logic [FRAC_BITS-1:0]    f_s3;
	frac_t                   sat_s3, val_s3;

	assign q6_x6    = (Q60_W'(q6_s2) << 2) + (Q60_W'(q6_s2) << 1);
	assign sec_full = q60_s2 - q6_x6;
	assign f_prod   = (REM_W+FR_M_W)'(rem_s2) * (REM_W+FR_M_W)'(FR_M);

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			sector_s3 <= sec_full[SEC_W-1:0];
			f_s3      <= f_prod[2*REM_W +: FRAC_BITS];
			sat_s3    <= sat_s2;
			val_s3    <= val_s2;
		end
	end

	// Stage 4: S*f, S*(1-f) and p = V*(1-S)
	frac_t                 f_comp;
	frac_t                 s_comp;
	logic [2*FRAC_W-1:0]   sf_prod, sfc_prod, p_prod;
	frac_t                 sf_s4, sfc_s4, p_s4, val_s4;
	logic [SEC_W-1:0]      sector_s4;

	assign f_comp   = ONE - FRAC_W'(f_s3);
	assign s_comp   = ONE - sat_s3;
	assign sf_prod  = (2*FRAC_W)'(sat_s3) * (2*FRAC_W)'(f_s3);
	assign sfc_prod = (2*FRAC_W)'(sat_s3) * (2*FRAC_W)'(f_comp);
	assign p_prod   = (2*FRAC_W)'(val_s3) * (2*FRAC_W)'(s_comp);

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			sf_s4     <= sf_prod[FRAC_BITS +: FRAC_W];
			sfc_s4    <= sfc_prod[FRAC_BITS +: FRAC_W];
			p_s4      <= p_prod[FRAC_BITS +: FRAC_W];
			val_s4    <= val_s3;
			sector_s4 <= sector_s3;
		end
	end

	// Stage 5: q = V*(1-S*f), t = V*(1-S*(1-f))
	// With zero saturation p, q and t all equal V, which gives grey.
	logic [2*FRAC_W-1:0] q_prod, t_prod;
	frac_t               q_s5, t_s5, p_s5, val_s5;
	logic [SEC_W-1:0]    sector_s5;

	assign q_prod = (2*FRAC_W)'(val_s4) * (2*FRAC_W)'(ONE - sf_s4);
	assign t_prod = (2*FRAC_W)'(val_s4) * (2*FRAC_W)'(ONE - sfc_s4);

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			q_s5      <= q_prod[FRAC_BITS +: FRAC_W];
			t_s5      <= t_prod[FRAC_BITS +: FRAC_W];
			p_s5      <= p_s4;
			val_s5    <= val_s4;
			sector_s5 <= sector_s4;
		end
	end

	// Stage 6: route V, p, q, t by sector and scale to eight bits
	frac_t r_sel, g_sel, b_sel;
	chan_t red_s6, green_s6, blue_s6;

	always_comb begin
		unique case (sector_s5)
			SEC_RED_YEL: begin r_sel = val_s5; g_sel = t_s5;   b_sel = p_s5;   end
			SEC_YEL_GRN: begin r_sel = q_s5;   g_sel = val_s5; b_sel = p_s5;   end
			SEC_GRN_CYN: begin r_sel = p_s5;   g_sel = val_s5; b_sel = t_s5;   end
			SEC_CYN_BLU: begin r_sel = p_s5;   g_sel = q_s5;   b_sel = val_s5; end
			SEC_BLU_MAG: begin r_sel = t_s5;   g_sel = p_s5;   b_sel = val_s5; end
			SEC_MAG_RED: begin r_sel = val_s5; g_sel = p_s5;   b_sel = q_s5;   end
			default:     begin r_sel = val_s5; g_sel = p_s5;   b_sel = q_s5;   end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			red_s6   <= to_byte(r_sel);
			green_s6 <= to_byte(g_sel);
			blue_s6  <= to_byte(b_sel);
		end
	end

	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

	// Checks on the divider chain and the stall logic
	`ASSERT_SAME(a_rem_range, clk, arst_n, vld_s2, rem_s2 < REM_W'(60))
	`ASSERT_SAME(a_sector_range, clk, arst_n, vld_s3, sector_s3 <= SEC_MAG_RED)
	`ASSERT_SAME(a_full_on_stall, clk, arst_n, !in_ready, vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6)
	`ASSERT_NEXT(a_no_drop, clk, arst_n, vld_s5 && adv_s6, vld_s6)

endmodule

### sim/hsv_to_rgb_checker.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Watches both channels of the converter, works out the colour that each
// accepted input word must turn into and compares every output word with the
// oldest outstanding colour, field by field. Counts failures for the top.
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [hsv2rgb_pkg::HUE_W-1:0] hue_degrees,
	input  hsv2rgb_pkg::frac_t            saturation,
	input  hsv2rgb_pkg::frac_t            brightness,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  hsv2rgb_pkg::chan_t            red,
	input  hsv2rgb_pkg::chan_t            green,
	input  hsv2rgb_pkg::chan_t            blue,
	output int                            errors,
	output int                            pending,
	output int                            results
);
	import hsv2rgb_pkg::*;

	// Six 60-degree slices of the hue circle
	typedef enum logic [2:0] {
		SECTOR_RED_YELLOW,
		SECTOR_YELLOW_GREEN,
		SECTOR_GREEN_CYAN,
		SECTOR_CYAN_BLUE,
		SECTOR_BLUE_MAGENTA,
		SECTOR_MAGENTA_RED
	} hue_sector_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} rgb_t;

	rgb_t colour_q[$];
	rgb_t want;

	// Scale a Q16 fraction to a byte, truncating
	function automatic chan_t to_channel(input logic [63:0] x);
		logic [63:0] c;
		c = (x * 255) >> FRAC_BITS;
		return (c > 255) ? chan_t'(255) : c[CHAN_W-1:0];
	endfunction

	// Hexcone conversion of one colour word
	function automatic rgb_t hsv_colour(input logic [HUE_W-1:0] h_in, input frac_t s_in,
			input frac_t v_in);
		logic [63:0] one_q, hue, s, v, rem, f, p, q, t, r, g, b;
		hue_sector_t sector;
		rgb_t c;
		one_q = 64'(ONE);
		hue = 64'(h_in) % 360;
		s = (64'(s_in) > one_q) ? one_q : 64'(s_in);
		v = (64'(v_in) > one_q) ? one_q : 64'(v_in);
		if (s == 0) begin
			// no saturation: plain grey at the brightness
			r = v;
			g = v;
			b = v;
		end else begin
			sector = hue_sector_t'(hue / 60);
			rem = hue % 60;
			f = (rem << FRAC_BITS) / 60;
			p = (v * (one_q - s)) >> FRAC_BITS;
			q = (v * (one_q - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
			t = (v * (one_q - ((s * (one_q - f)) >> FRAC_BITS))) >> FRAC_BITS;
			case (sector)
				SECTOR_RED_YELLOW: begin
					r = v; g = t; b = p;
				end
				SECTOR_YELLOW_GREEN: begin
					r = q; g = v; b = p;
				end
				SECTOR_GREEN_CYAN: begin
					r = p; g = v; b = t;
				end
				SECTOR_CYAN_BLUE: begin
					r = p; g = q; b = v;
				end
				SECTOR_BLUE_MAGENTA: begin
					r = t; g = p; b = v;
				end
				default: begin
					r = v; g = p; b = q;
				end
			endcase
		end
		c.r = to_channel(r);
		c.g = to_channel(g);
		c.b = to_channel(b);
		return c;
	endfunction

	task automatic report_field(input string name, input chan_t exp_val, input chan_t act_val);
		if (exp_val !== act_val) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
			errors++;
		end
	endtask

	// Retire output words against the oldest colour, then log new input words
	always @(posedge clk) begin
		if (!arst_n) begin
			colour_q.delete();
			errors = 0;
			results = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (colour_q.size() == 0) begin
					$error("unexpected output word: red %0d green %0d blue %0d",
						red, green, blue);
					errors++;
				end else begin
					want = colour_q.pop_front();
					report_field("red", want.r, red);
					report_field("green", want.g, green);
					report_field("blue", want.b, blue);
					results++;
				end
			end
			if (in_valid && in_ready)
				colour_q.push_back(hsv_colour(hue_degrees, saturation, brightness));
		end
		pending = colour_q.size();
	end

endmodule

### sim/hsv_to_rgb_converter_tb.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives colour words into the converter through a directed set of corner
// colours and then a long random stream, with random gaps on both sides, a
// calm stretch and one long output stall. The checker beside the block
// predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;
	import hsv2rgb_pkg::*;

	localparam int RANDOM_WORDS   = 1130;
	localparam int CALM_FIRST     = 300;
	localparam int CALM_LAST      = 550;
	localparam int STALL_AT       = 700;
	localparam int STALL_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int IDLE_PERCENT   = 9;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [HUE_W-1:0] hue_degrees;
	frac_t            saturation;
	frac_t            brightness;
	logic             out_valid;
	logic             out_ready;
	chan_t            red;
	chan_t            green;
	chan_t            blue;

	int   errors;
	int   pending;
	int   results;
	int   quiet_cycles = 0;
	logic calm = 1'b0;
	logic stall_req = 1'b0;
	logic stall_done = 1'b0;

	hsv_to_rgb_converter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.hue_degrees (hue_degrees),
		.saturation  (saturation),
		.brightness  (brightness),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

	hsv_to_rgb_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.hue_degrees (hue_degrees),
		.saturation  (saturation),
		.brightness  (brightness),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.errors      (errors),
		.pending     (pending),
		.results     (results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abort when no word moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			if (stall_req && !stall_done) begin
				out_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				stall_done = 1'b1;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
				@(posedge clk);
			end
		end
	end

	// Offer one colour word, with random gaps, and hold it until taken
	task automatic send_colour(input logic [HUE_W-1:0] h, input frac_t s, input frac_t v);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		hue_degrees <= h;
		saturation  <= s;
		brightness  <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	initial begin
		int               n;
		int               kind;
		logic [HUE_W-1:0] h;
		frac_t            s;
		frac_t            v;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		hue_degrees = '0;
		saturation  = '0;
		brightness  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner colours: sector edges, hue wrap, grey, full and over-range S and V
		send_colour(16'd0, ONE, ONE);
		send_colour(16'd59, ONE, ONE);
		send_colour(16'd60, ONE, ONE);
		send_colour(16'd119, ONE, ONE);
		send_colour(16'd120, ONE, ONE);
		send_colour(16'd180, ONE, ONE);
		send_colour(16'd239, 17'd40000, ONE);
		send_colour(16'd240, 17'd40000, 17'd50000);
		send_colour(16'd300, 17'd30000, 17'd50000);
		send_colour(16'd359, ONE, ONE);
		send_colour(16'd360, ONE, ONE);
		send_colour(16'd719, 17'd20000, 17'd60000);
		send_colour(16'hFFFF, ONE, ONE);
		send_colour(16'd90, 17'd0, 17'd0);
		send_colour(16'd90, 17'd0, ONE);
		send_colour(16'd90, 17'd0, 17'h1FFFF);
		send_colour(16'd210, 17'h1FFFF, ONE);
		send_colour(16'd30, 17'd1, ONE);
		send_colour(16'd330, ONE, 17'd1);
		send_colour(16'd150, ONE, 17'h1FFFF);
		send_colour(16'd270, 17'h10001, 17'h10001);
		send_colour(16'd45, 17'hFFFF, 17'hFFFF);
		send_colour(16'h8000, 17'd0, 17'hFFFF);
		send_colour(16'd0, 17'd0, 17'd0);

		// Random stream, with a calm stretch and a long output stall
		for (n = 0; n < RANDOM_WORDS; n++) begin
			calm = (n >= CALM_FIRST) && (n < CALM_LAST);
			if (n == STALL_AT)
				stall_req = 1'b1;
			kind = int'($urandom_range(15));
			h = HUE_W'($urandom_range(65535));
			s = FRAC_W'($urandom_range(65536));
			v = FRAC_W'($urandom_range(65536));
			case (kind)
				0: s = '0;
				1: s = FRAC_W'($urandom_range(131071, 65536));
				2: v = FRAC_W'($urandom_range(131071, 65536));
				3: h = HUE_W'(360 * $urandom_range(180) + 60 * $urandom_range(1, 6) - 1
					+ $urandom_range(2));
				4: h = HUE_W'($urandom_range(359));
				5: begin
					s = ONE;
					v = ONE;
				end
				default: ;
			endcase
			send_colour(h, s, v);
		end
		in_valid <= 1'b0;

		// Drain the pipeline
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d colour words over every hue sector, hue wrap-around,", results);
		$display("grey, over-range saturation and brightness, and one long output stall.");
		if (errors == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			if (pending != 0)
				$error("%0d expected colours never came out", pending);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_checker.sv
sim/hsv_to_rgb_converter_tb.sv
